// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the pointer velocity tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/pvt_pkg.sv =====
// Shared types and constants of the pointer velocity tracker.
`default_nettype none
package pvt_pkg;
    localparam int TRACKER_COUNT_DEF = 16;
    localparam int TIMEOUT_MS_DEF = 1000;
    localparam int UNDEFINED_DIRECTION_DEF = 255;
    localparam int JUMP_LIMIT_Q10 = 1024;
    localparam int TWO_TRACKERS = 2;
    localparam logic [0:0] REQ_MOTION = 1'b0;
    localparam logic [0:0] REQ_RESTART = 1'b1;

    // Contents of one tracker as it moves along the row.
    typedef struct packed {
        logic [31:0] acc_dx;
        logic [31:0] acc_dy;
        logic [31:0] stamp;
        logic [7:0]  sector_bits;
    } t_track;

    // Control from the sequencer to every cell.
    typedef struct packed {
        logic        add;    // add delta to the cell's tracker
        logic        shift;  // shift the row by one place
        logic        wipe;   // clear tracker
        logic [31:0] dx;
        logic [31:0] dy;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ===== rtl/pvt_if.sv =====
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface pvt_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pvt_cell.sv =====
// One tracker cell of the row: holds a tracker and passes it on.
`default_nettype none
module pvt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pvt_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_wipe_me,
    input  wire pvt_pkg::t_track    i_prev,
    output pvt_pkg::t_track         o_track
);
    import pvt_pkg::*;
    t_track r_trk, n_trk;

    always_comb begin
        n_trk = r_trk;
        if (i_ctl.shift) n_trk = i_prev;
        // the delta lands on whichever tracker this cell holds next
        if (i_ctl.add) begin
            n_trk.acc_dx = n_trk.acc_dx + i_ctl.dx;
            n_trk.acc_dy = n_trk.acc_dy + i_ctl.dy;
        end
        if (i_ctl.wipe || i_wipe_me) n_trk = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_trk <= '0;
        else r_trk <= n_trk;
    end
    assign o_track = r_trk;
endmodule
`default_nettype wire

// ===== rtl/pvt_speed.sv =====
// Serial speed unit: squares, bit-pair square root, then restoring divide.
`default_nettype none
`include "assert_macros.svh"
module pvt_speed (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dx,
    input  wire logic [31:0] i_dy,
    input  wire logic [31:0] i_dt,
    output logic             o_done,
    output logic [31:0]      o_speed
);
    import pvt_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_SQX, S_SQY, S_ROOT, S_DIV, S_DONE} t_state;
    t_state      r_st;
    logic [31:0] r_ax, r_ay, r_sum, r_v, r_r, r_bit, r_dt, r_q, r_rem;
    logic [5:0]  r_cnt;
    logic [32:0] w_try;
    logic [31:0] w_rb;

    assign w_rb  = r_r + r_bit;
    assign w_try = {r_rem[31:0], r_q[31]} - {1'b0, r_dt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_st)
                S_IDLE: if (i_start) begin
                    r_ax <= i_dx[31] ? 32'd0 - i_dx : i_dx;
                    r_ay <= i_dy[31] ? 32'd0 - i_dy : i_dy;
                    r_dt <= (i_dt == 32'd0) ? 32'd1 : i_dt;
                    r_st <= S_SQX;
                end
                S_SQX: begin
                    r_sum <= r_ax * r_ax;
                    r_st <= S_SQY;
                end
                S_SQY: begin
                    r_v   <= r_sum + r_ay * r_ay;
                    r_r   <= '0;
                    r_bit <= 32'h4000_0000;
                    r_st  <= S_ROOT;
                end
                S_ROOT: begin
                    // bit starts at 2^30; leading steps with bit > v fall through
                    if (r_bit == 32'd0) begin
                        r_q   <= r_r;
                        r_rem <= '0;
                        r_cnt <= 6'd32;
                        r_st  <= S_DIV;
                    end else begin
                        if (r_v >= w_rb) begin
                            r_v <= r_v - w_rb;
                            r_r <= (r_r >> 1) + r_bit;
                        end else begin
                            r_r <= r_r >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        o_speed <= r_q;
                        o_done  <= 1'b1;
                        r_st    <= S_IDLE;
                    end else begin
                        if (!w_try[32]) begin
                            r_rem <= w_try[31:0];
                            r_q   <= {r_q[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[30:0], r_q[31]};
                            r_q   <= {r_q[30:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `PVT_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
endmodule
`default_nettype wire

// ===== rtl/pointer_velocity_tracker_unit.sv =====
// Top level of the pointer velocity tracker.
// Keeps TRACKER_COUNT trackers in a shifting row of cells; slot 0 is always
// the newest tracker, slot k the one k events older. A motion transfer adds
// its delta and shifts the row in the same cycle, then walks older trackers
// through a serial speed unit (squares, root and divide steps); no new item
// is accepted while a walk runs or a result waits to be taken, and a restart
// gives no result. With averaging off only the first two cells are used. A
// write of the averaging register clears the row.
`default_nettype none
`include "assert_macros.svh"
module pointer_velocity_tracker_unit #(
    parameter int TRACKER_COUNT = pvt_pkg::TRACKER_COUNT_DEF,
    parameter int TIMEOUT_MS = pvt_pkg::TIMEOUT_MS_DEF,
    parameter int UNDEFINED_DIRECTION = pvt_pkg::UNDEFINED_DIRECTION_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pvt_if.sink              in_ch,
    pvt_if.source            out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pvt_pkg::*;
    localparam int IW = $clog2(TRACKER_COUNT);
    typedef enum logic [2:0] {S_IDLE, S_ADD, S_FIRST, S_WAIT, S_NEXT, S_OUT} t_state;

    t_state      r_st;
    logic        r_avg;
    logic [IW:0] r_off;
    logic [31:0] r_now, r_dx, r_dy, r_res, r_init;
    logic [7:0]  r_dir, r_mask;
    logic        r_start, r_ovld;
    logic [15:0] r_vel;
    logic        w_cfg_wr, w_acc, w_rst;
    t_cell_ctl   w_ctl;
    t_track      w_trk [TRACKER_COUNT];
    t_track      w_head_new, w_sel;
    logic [TRACKER_COUNT-1:0] w_wipe;
    logic [IW:0] w_n;
    logic [31:0] w_dt, w_sp, w_diff;
    logic        w_done;
    logic [7:0]  w_dirn;

    assign pready   = 1'b1;
    assign prdata   = {31'd0, r_avg};
    assign w_cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign w_n      = r_avg ? (IW+1)'(TRACKER_COUNT) : (IW+1)'(TWO_TRACKERS);
    assign in_ch.ready = (r_st == S_IDLE) && !r_ovld;
    assign w_acc    = in_ch.valid && in_ch.ready;
    assign w_rst    = w_acc && (in_ch.data[82] == REQ_RESTART);
    assign out_ch.valid = r_ovld;
    assign out_ch.data  = r_vel;

    // in_ch.data layout: {req_type, delta_x, delta_y, event_time, direction_mask}
    always_comb begin
        w_ctl = '0;
        w_ctl.dx = r_dx;
        w_ctl.dy = r_dy;
        w_ctl.wipe = w_cfg_wr;
        w_ctl.add = (r_st == S_ADD);
        w_ctl.shift = (r_st == S_ADD);
        w_head_new = '0;
        w_head_new.stamp = r_now;
        w_head_new.sector_bits = r_mask;
        w_wipe = '0;
        if (w_rst) begin
            for (int k = 1; k < TRACKER_COUNT; k++)
                if (IW'(k) < w_n[IW-1:0] || w_n[IW]) w_wipe[k] = 1'b1;
        end
    end

    // Slot 0 is loaded from head input on shift; each later slot from the one before
    genvar g;
    generate
        for (g = 0; g < TRACKER_COUNT; g++) begin : g_cell
            t_track w_prev;
            t_cell_ctl w_c;
            always_comb begin
                w_c = w_ctl;
                if (g == 0) w_prev = w_head_new;
                else w_prev = w_trk[g-1];
                // cells beyond the active count neither add nor shift
                if (!r_avg && g >= TWO_TRACKERS) begin
                    w_c.add = 1'b0;
                    w_c.shift = 1'b0;
                end
                if (g == 0) w_c.add = 1'b0;
                // A restart rewrites slot 0 directly, keeping its displacement.
                if (g == 0 && w_rst) begin
                    w_prev = w_trk[0];
                    w_prev.stamp = in_ch.data[39:8];
                    w_prev.sector_bits = 8'(UNDEFINED_DIRECTION);
                    w_c.shift = 1'b1;
                end
            end
            pvt_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_c),
                .i_wipe_me(w_wipe[g]), .i_prev(w_prev), .o_track(w_trk[g])
            );
        end
    endgenerate

    assign w_sel  = w_trk[r_off[IW-1:0]];
    assign w_dt   = r_now - w_sel.stamp;
    assign w_dirn = r_dir & w_sel.sector_bits;
    assign w_diff = (r_init > w_sp) ? r_init - w_sp : w_sp - r_init;

    pvt_speed u_speed (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_dx(w_sel.acc_dx), .i_dy(w_sel.acc_dy),
        .i_dt((w_dt > 32'(TIMEOUT_MS)) ? 32'(TIMEOUT_MS) : w_dt),
        .o_done(w_done), .o_speed(w_sp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_avg <= 1'b0;
            r_ovld <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (out_ch.valid && out_ch.ready) r_ovld <= 1'b0;
            if (w_cfg_wr) r_avg <= pwdata[0];
            case (r_st)
                S_IDLE: if (w_acc) begin
                    r_now <= in_ch.data[39:8];
                    r_dx  <= {{11{in_ch.data[81]}}, in_ch.data[81:61]};
                    r_dy  <= {{11{in_ch.data[60]}}, in_ch.data[60:40]};
                    r_mask <= in_ch.data[7:0];
                    r_dir <= in_ch.data[7:0];
                    r_res <= '0;
                    r_init <= '0;
                    r_off <= (IW+1)'(1);
                    if (in_ch.data[82] == REQ_MOTION) r_st <= S_ADD;
                end
                S_ADD: r_st <= S_FIRST;
                S_FIRST: begin
                    if (r_off >= w_n || w_sel.stamp > r_now) r_st <= S_OUT;
                    else begin
                        r_start <= 1'b1;
                        r_st <= S_WAIT;
                    end
                end
                S_WAIT: if (w_done) begin
                    r_st <= S_NEXT;
                    if (w_dt > 32'(TIMEOUT_MS)) begin
                        if (r_off == (IW+1)'(1)) r_res <= w_sp;
                        r_st <= S_OUT;
                    end else if (w_dirn == 8'd0) begin
                        if (r_off == (IW+1)'(1)) r_res <= w_sp;
                        r_st <= S_OUT;
                    end else if (r_init == 32'd0 || r_off <= (IW+1)'(2)) begin
                        r_res <= w_sp;
                        r_init <= w_sp;
                    end else if (w_diff > 32'(JUMP_LIMIT_Q10)) begin
                        r_st <= S_OUT;
                    end else begin
                        r_res <= w_sp;
                    end
                    r_dir <= w_dirn;
                end
                S_NEXT: begin
                    r_off <= r_off + (IW+1)'(1);
                    r_st <= S_FIRST;
                end
                S_OUT: begin
                    r_vel <= r_res[15:0];
                    r_ovld <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `PVT_ASSERT_IMP(a_busy_no_ready, i_clk, i_rst_n, r_st != S_IDLE, !in_ch.ready)
    `PVT_ASSERT_IMP(a_off_range, i_clk, i_rst_n, r_st == S_WAIT, r_off != '0)
    `PVT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ovld && !out_ch.ready, r_ovld)
endmodule
`default_nettype wire

// ===== sim/pointer_velocity_tracker_unit_tb.sv =====
// Self-checking testbench of the pointer velocity tracker unit.
`default_nettype none
module pointer_velocity_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pvt_pkg::*;

    localparam int IN_W = 83;
    localparam int SETTLE_CYCLES = 1200;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int TRK = TRACKER_COUNT_DEF;

    typedef struct packed {
        logic [0:0]         req;
        logic signed [20:0] dx;
        logic signed [20:0] dy;
        logic [31:0]        t_ms;
        logic [7:0]         mask;
    } t_motion;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pvt_if #(IN_W) in_ch ();
    pvt_if #(16)   out_ch ();

    pointer_velocity_tracker_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial in_ch.valid = 1'b0;
    initial in_ch.data = '0;
    initial out_ch.ready = 1'b0;

    // tracker state mirrored by the speed predictor
    logic [31:0] trk_dx [TRK];
    logic [31:0] trk_dy [TRK];
    logic [31:0] trk_stamp [TRK];
    logic [7:0]  trk_dir [TRK];
    int unsigned trk_head;
    logic        avg_on;

    t_motion      pending_q[$];
    logic [15:0]  speed_q[$];
    int           send_idle_pct = 0, recv_stall_pct = 0;
    int           errors = 0, n_results = 0, n_motion = 0, n_restart = 0;
    int           hold_tok = 0, hold_seen = 0, hold_left = 0;
    int           quiet_cycles = 0;
    logic [31:0]  run_ms;

    always #2 i_clk = ~i_clk;

    function automatic void clear_trackers();
        for (int k = 0; k < TRK; k++) begin
            trk_dx[k] = '0; trk_dy[k] = '0; trk_stamp[k] = '0; trk_dir[k] = '0;
        end
        trk_head = 0;
    endfunction

    function automatic logic [31:0] isqrt32(logic [31:0] v);
        logic [31:0] bitv, r;
        bitv = 32'h4000_0000;
        r = '0;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] tracker_speed(int unsigned s, logic [31:0] dt);
        logic [31:0] ax, ay;
        ax = trk_dx[s][31] ? 32'd0 - trk_dx[s] : trk_dx[s];
        ay = trk_dy[s][31] ? 32'd0 - trk_dy[s] : trk_dy[s];
        if (dt == 0) dt = 1;
        return isqrt32(ax * ax + ay * ay) / dt;
    endfunction

    function automatic int unsigned older_slot(int unsigned off, int unsigned n);
        return (trk_head % n + n - off % n) % n;
    endfunction

    // advance the tracker ring by one transfer; a motion transfer also queues the expected speed
    function automatic void predict_speed(t_motion m);
        int unsigned n, s, hd;
        logic [31:0] dx, dy, dt, v, res, init, diff;
        logic [7:0]  dir;
        n = avg_on ? TRK : TWO_TRACKERS;
        if (m.req == REQ_RESTART) begin
            for (int unsigned k = 1; k < n; k++) begin
                s = older_slot(k, n);
                trk_stamp[s] = '0; trk_dir[s] = '0; trk_dx[s] = '0; trk_dy[s] = '0;
            end
            hd = older_slot(0, n);
            trk_stamp[hd] = m.t_ms;
            trk_dir[hd] = UNDEFINED_DIRECTION_DEF[7:0];
            return;
        end
        dx = 32'(m.dx);
        dy = 32'(m.dy);
        for (int unsigned k = 0; k < n; k++) begin
            trk_dx[k] = trk_dx[k] + dx;
            trk_dy[k] = trk_dy[k] + dy;
        end
        hd = (trk_head % n + 1) % n;
        trk_head = hd;
        trk_dx[hd] = '0; trk_dy[hd] = '0;
        trk_stamp[hd] = m.t_ms;
        trk_dir[hd] = m.mask;
        dir = trk_dir[hd];
        res = '0;
        init = '0;
        for (int unsigned k = 1; k < n; k++) begin
            s = older_slot(k, n);
            if (trk_stamp[s] > m.t_ms) break;
            dt = m.t_ms - trk_stamp[s];
            if (dt > TIMEOUT_MS_DEF) begin
                if (k == 1) res = tracker_speed(s, TIMEOUT_MS_DEF);
                break;
            end
            v = tracker_speed(s, dt);
            dir = dir & trk_dir[s];
            if (dir == 0) begin
                if (k == 1) res = v;
                break;
            end
            if (init == 0 || k <= 2) begin
                res = v;
                init = v;
            end else begin
                diff = init > v ? init - v : v - init;
                if (diff > JUMP_LIMIT_Q10) break;
                res = v;
            end
        end
        speed_q.push_back(res[15:0]);
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sender: hold the payload until it is taken, then offer the next item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_speed(t_motion'(in_ch.data));
                if (in_ch.data[IN_W-1] == REQ_RESTART) n_restart++;
                else n_motion++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_q.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (speed_q.size() == 0) begin
                    report_mismatch("unexpected velocity", out_ch.data, 16'd0);
                end else begin
                    logic [15:0] want;
                    want = speed_q.pop_front();
                    if (out_ch.data !== want) report_mismatch("velocity", out_ch.data, want);
                end
            end
            if (hold_tok != hold_seen) begin
                hold_seen = hold_tok;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] addr, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 2'd0) begin
            avg_on = value[0];
            clear_trackers();
        end
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || speed_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_motion mk(logic [0:0] rq, int x, int y, logic [31:0] t, logic [7:0] m);
        t_motion r;
        r.req = rq; r.dx = x[20:0]; r.dy = y[20:0]; r.t_ms = t; r.mask = m;
        return r;
    endfunction

    function automatic int rand_delta();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 1048575 : -1048576;
            1: return int'($urandom_range(2097151)) - 1048576;
            default: return int'($urandom_range(8191)) - 4096;
        endcase
    endfunction

    function automatic t_motion rand_item();
        logic [7:0] m;
        case ($urandom_range(19))
            0: run_ms = run_ms + 1001 + $urandom_range(2000);
            1: run_ms = run_ms - $urandom_range(50);
            2: run_ms = $urandom;
            default: run_ms = run_ms + $urandom_range(60);
        endcase
        case ($urandom_range(9))
            0: m = 8'($urandom);
            1: m = 8'h00;
            2, 3: m = 8'hFF;
            default: m = 8'h81 | 8'($urandom);
        endcase
        if ($urandom_range(19) == 0)
            return mk(REQ_RESTART, rand_delta(), rand_delta(), run_ms, 8'($urandom));
        return mk(REQ_MOTION, rand_delta(), rand_delta(), run_ms, m);
    endfunction

    task automatic load_directed();
        pending_q.push_back(mk(REQ_MOTION, 1048575, -1048576, 32'd10, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, -1048576, 1048575, 32'd10, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 0, 0, 32'd20, 8'h0F));
        pending_q.push_back(mk(REQ_MOTION, 4000, 3000, 32'd25, 8'h01));
        pending_q.push_back(mk(REQ_MOTION, 4000, 3000, 32'd30, 8'h02));
        pending_q.push_back(mk(REQ_MOTION, 100, 100, 32'd5, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 200, -200, 32'd2000, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 2000, 2000, 32'd2010, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 2000, 2000, 32'd2011, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 2000, 2000, 32'd2012, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 900000, 900000, 32'd2013, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 10, 10, 32'd2014, 8'hFF));
        pending_q.push_back(mk(REQ_RESTART, -1048576, 1048575, 32'd2020, 8'h00));
        pending_q.push_back(mk(REQ_MOTION, 500, 0, 32'd2030, 8'h00));
        pending_q.push_back(mk(REQ_MOTION, 500, 0, 32'd2040, 8'hAA));
        pending_q.push_back(mk(REQ_MOTION, -1048576, -1048576, 32'hFFFF_FFFF, 8'h55));
        pending_q.push_back(mk(REQ_MOTION, 1048575, 1048575, 32'hFFFF_FFFF, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 1, -1, 32'd0, 8'hFF));
        pending_q.push_back(mk(REQ_RESTART, 0, 0, 32'hFFFF_FFFF, 8'hFF));
        pending_q.push_back(mk(REQ_MOTION, 3, 4, 32'd100, 8'hFF));
    endtask

    task automatic load_random(int count);
        repeat (count) pending_q.push_back(rand_item());
    endtask

    initial begin
        avg_on = 1'b0;
        clear_trackers();
        run_ms = 32'd5000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_directed();
        drain();

        apb_write(2'd0, 32'd1);
        load_directed();
        load_random(130);
        send_idle_pct = 66;
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 66;
        hold_tok = hold_tok + 1;
        load_random(150);
        drain();

        apb_write(2'd2, 32'd1);
        apb_write(2'd0, 32'hFFFF_FFFE);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        load_random(70);
        drain();
        // let everything come back before offering more
        load_random(80);
        drain();

        apb_write(2'd0, 32'hFFFF_FFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_random(130);
        drain();

        $display("covered %0d motion and %0d restart transfers, %0d velocities checked",
                 n_motion, n_restart, n_results);
        $display("with two and sixteen trackers, sender gaps and receiver stalls");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
